// ===== hw/rtl/aplm_pkg.sv =====
// Shared types, register codes and full-scale constants of the audio peak level meter.
// Used by the channel interfaces, the top level and the port checker.
package aplm_pkg;

   localparam int SampleBits  = 32;
   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 32;

   typedef logic [SampleBits-1:0]   sample_type;
   typedef logic [SampleBits-1:0]   level_type;
   typedef logic [CsrIndexBits-1:0] csr_index_type;
   typedef logic [CsrDataBits-1:0]  csr_data_type;

   // configuration register indexes
   localparam csr_index_type REG_SAMPLE_WIDTH = 2'd0;
   localparam csr_index_type REG_SAMPLE_KIND  = 2'd1;
   localparam csr_index_type REG_BIG_ENDIAN   = 2'd2;

   // sample_width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   // sample_kind codes
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_FLOAT    = 2'd2;

   localparam level_type FS_U8  = 32'd255;
   localparam level_type FS_S8  = 32'd127;
   localparam level_type FS_U16 = 32'd65535;
   localparam level_type FS_S16 = 32'd32767;
   localparam level_type FS_U32 = 32'hffff_ffff;
   localparam level_type FS_S32 = 32'h7fff_ffff;
   localparam level_type FS_NONE = 32'd0;

   // Full scale of a format; zero marks an unsupported combination.
   function automatic level_type full_scale_of(logic [1:0] width, logic [1:0] kind);
      level_type fs;
      fs = FS_NONE;
      unique case (width)
         WIDTH_8: begin
            if (kind == KIND_UNSIGNED)    fs = FS_U8;
            else if (kind == KIND_SIGNED) fs = FS_S8;
         end
         WIDTH_16: begin
            if (kind == KIND_UNSIGNED)    fs = FS_U16;
            else if (kind == KIND_SIGNED) fs = FS_S16;
         end
         WIDTH_32: begin
            if (kind == KIND_UNSIGNED)    fs = FS_U32;
            else if (kind == KIND_SIGNED) fs = FS_S32;
            else if (kind == KIND_FLOAT)  fs = FS_S32;
         end
         default: fs = FS_NONE;
      endcase
      return fs;
   endfunction

endpackage

// ===== hw/rtl/aplm_if.sv =====
// Valid/ready channel interfaces of the audio peak level meter:
// sample input, peak result and configuration write. Depends on aplm_pkg.
interface aplm_req_if;
   import aplm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_word;
   logic       last_of_buffer;
   modport source (output valid, sample_word, last_of_buffer, input ready);
   modport sink   (input valid, sample_word, last_of_buffer, output ready);
endinterface

interface aplm_rsp_if;
   import aplm_pkg::*;
   logic      valid;
   logic      ready;
   level_type peak_level;
   level_type full_scale;
   modport source (output valid, peak_level, full_scale, input ready);
   modport sink   (input valid, peak_level, full_scale, output ready);
endinterface

interface aplm_csr_if;
   import aplm_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/audio_peak_level_meter_unit.sv =====
// Audio peak level meter: top level, input register and result register around the decode.
// Depends on aplm_pkg and the channel interfaces in aplm_if.sv.
//
// Usage:
//   req_ch carries one raw sample word per transaction plus a last_of_buffer
//   flag. The configured width, kind (unsigned, signed, float) and byte order
//   select the decode; the magnitude feeds a running maximum.
//   rsp_ch carries one transaction for each sample marked last: the buffer
//   peak clamped to full scale, and the full scale of the format. For an
//   unsupported format the previous peak is repeated with full scale zero.
//   csr_ch writes the configuration registers by index; it is always ready.
//   Write it only while no sample is in flight.
// Result path: the last sample of a buffer is taken into the input register,
//   then its result into the result register that drives rsp_ch.valid.
// Throughput: one sample per cycle; samples not marked last keep flowing
//   while a result waits. When the receiver stalls with a result held, the
//   next last sample waits in the input register and req_ch.ready drops
//   until the held result is taken.
// Reset: synchronous; clears the pipeline, running maximum and stored peak
//   and restores 16-bit signed little-endian.
module audio_peak_level_meter_unit (
   input logic          clock,
   input logic          reset,
   aplm_req_if.sink     req_ch,
   aplm_rsp_if.source   rsp_ch,
   aplm_csr_if.sink     csr_ch
);
   import aplm_pkg::*;

   logic [1:0] sample_width_ff;
   logic [1:0] sample_kind_ff;
   logic       big_endian_ff;

   logic       s1_valid_ff;
   sample_type s1_word_ff;
   logic       s1_last_ff;

   level_type  running_max_ff, running_max_in;
   level_type  stored_peak_ff, stored_peak_in;

   logic       rsp_valid_ff;
   level_type  rsp_peak_ff;
   level_type  rsp_fs_ff;

   logic       out_free;
   logic       s1_take;
   logic       s1_fire;
   level_type  fs_now;
   level_type  new_max;

   // decode signals
   logic [7:0]  b0, b1, b2, b3;
   logic [15:0] v16;
   sample_type  v32;
   level_type   mag;
   logic [7:0]  f_exp, f_exp_eff, f_shift;
   logic [23:0] f_man;
   logic [54:0] f_prod, f_shifted;
   level_type   f_mag;

   // ---------------- configuration ----------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_width_ff <= WIDTH_16;
         sample_kind_ff  <= KIND_SIGNED;
         big_endian_ff   <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SAMPLE_WIDTH: sample_width_ff <= csr_ch.data[1:0];
            REG_SAMPLE_KIND:  sample_kind_ff  <= csr_ch.data[1:0];
            REG_BIG_ENDIAN:   big_endian_ff   <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_take      = !s1_valid_ff || !s1_last_ff || out_free;
   assign s1_fire      = s1_valid_ff && s1_take;
   assign req_ch.ready = s1_take;

   // ---------------- stage 1: input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_word_ff <= req_ch.sample_word;
         s1_last_ff <= req_ch.last_of_buffer;
      end
   end

   // ---------------- decode and magnitude ----------------
   always_comb begin
      b0 = s1_word_ff[7:0];
      b1 = s1_word_ff[15:8];
      b2 = s1_word_ff[23:16];
      b3 = s1_word_ff[31:24];
      v16 = big_endian_ff ? {b0, b1} : {b1, b0};
      v32 = big_endian_ff ? {b0, b1, b2, b3} : s1_word_ff;

      // float: floor(|x| * (2^31 - 1)) as (m * (2^31 - 1)) >> (150 - e)
      f_exp     = v32[30:23];
      f_exp_eff = (f_exp == 8'd0) ? 8'd1 : f_exp;
      f_man     = {(f_exp != 8'd0), v32[22:0]};
      f_prod    = {f_man, 31'd0} - {31'd0, f_man};
      f_shift   = 8'd150 - f_exp_eff;
      f_shifted = f_prod >> f_shift[5:0];
      priority if (f_exp == 8'hff)        f_mag = FS_S32;
      else if (f_man == 24'd0)            f_mag = '0;
      else if (f_exp_eff >= 8'd150)       f_mag = FS_S32;
      else if (f_shift >= 8'd64)          f_mag = '0;
      else if (|f_shifted[54:31])         f_mag = FS_S32;
      else                                f_mag = {1'b0, f_shifted[30:0]};

      mag = '0;
      unique case (sample_width_ff)
         WIDTH_8: begin
            if (sample_kind_ff == KIND_UNSIGNED)
               mag = {24'd0, b0};
            else if (sample_kind_ff == KIND_SIGNED)
               mag = {24'd0, (b0[7] ? (~b0 + 8'd1) : b0)};
         end
         WIDTH_16: begin
            if (sample_kind_ff == KIND_UNSIGNED)
               mag = {16'd0, v16};
            else if (sample_kind_ff == KIND_SIGNED)
               mag = {16'd0, (v16[15] ? (~v16 + 16'd1) : v16)};
         end
         WIDTH_32: begin
            if (sample_kind_ff == KIND_UNSIGNED)
               mag = v32;
            else if (sample_kind_ff == KIND_SIGNED)
               mag = v32[31] ? (~v32 + 32'd1) : v32;
            else if (sample_kind_ff == KIND_FLOAT)
               mag = f_mag;
         end
         default: mag = '0;
      endcase
   end

   // ---------------- running maximum and peak ----------------
   always_comb begin
      fs_now  = full_scale_of(sample_width_ff, sample_kind_ff);
      new_max = (fs_now != FS_NONE && mag > running_max_ff) ? mag : running_max_ff;

      running_max_in = running_max_ff;
      stored_peak_in = stored_peak_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            running_max_in = '0;
            if (fs_now != FS_NONE)
               stored_peak_in = (new_max < fs_now) ? new_max : fs_now;
         end else begin
            running_max_in = new_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_max_ff <= '0;
         stored_peak_ff <= '0;
      end else begin
         running_max_ff <= running_max_in;
         stored_peak_ff <= stored_peak_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_fire && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_fire && s1_last_ff) begin
         rsp_peak_ff <= stored_peak_in;
         rsp_fs_ff   <= fs_now;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.peak_level = rsp_peak_ff;
   assign rsp_ch.full_scale = rsp_fs_ff;

endmodule

// ===== hw/rtl/aplm_checker.sv =====
// Port-level checker for the audio peak level meter and its bind to the top level.
// Depends on aplm_pkg and audio_peak_level_meter_unit.
module aplm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input aplm_pkg::level_type peak_level,
   input aplm_pkg::level_type full_scale
);
   import aplm_pkg::*;

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(peak_level) && $stable(full_scale))
      else $error("result changed while stalled");

   a_fs_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (full_scale == FS_NONE || full_scale == FS_U8 ||
                     full_scale == FS_S8 || full_scale == FS_U16 ||
                     full_scale == FS_S16 || full_scale == FS_U32 ||
                     full_scale == FS_S32))
      else $error("full scale not a format value");

   // peak is clamped whenever the format is supported
   a_peak_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && full_scale != FS_NONE |-> peak_level <= full_scale)
      else $error("peak above full scale");

endmodule

bind audio_peak_level_meter_unit aplm_checker u_aplm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .peak_level (rsp_ch.peak_level),
   .full_scale (rsp_ch.full_scale)
);

// ===== tb/audio_peak_level_meter_unit_tb.sv =====
// Self-checking bench for the audio peak level meter: drives raw sample words in
// bursts across all width/kind/byte-order formats and checks every peak result
// against an in-bench peak predictor. Depends on aplm_pkg, aplm_if.sv and the RTL.
module audio_peak_level_meter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aplm_pkg::*;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 8;
   localparam int ItemTarget = 1525;
   localparam int QuietLimit = 3000;
   localparam int LongHoldCycles = 400;
   localparam int SettleCycles = 6;

   localparam logic [1:0] WIDTH_RESERVED = 2'd3;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   typedef struct {
      sample_type word;
      logic       last;
   } sample_item_type;

   typedef struct {
      level_type peak_level;
      level_type full_scale;
   } peak_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aplm_req_if req_ch();
   aplm_rsp_if rsp_ch();
   aplm_csr_if csr_ch();

   audio_peak_level_meter_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // predictor copy of the configuration and the meter state
   logic [1:0] cfg_width = WIDTH_16;
   logic [1:0] cfg_kind = KIND_SIGNED;
   logic       cfg_big_endian = 1'b0;
   level_type  running_peak = '0;
   level_type  held_peak = '0;

   sample_item_type pending_samples[$];
   peak_result_type expected_peaks[$];

   int  mismatches = 0;
   int  peaks_checked = 0;
   int  queued_samples = 0;
   int  quiet_cycles = 0;
   bit  req_taken = 1'b0;

   // sender burst state
   int  burst_left = 1;
   int  gap_left = 0;

   // receiver stall state
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  pattern_mode = 0;
   int  pattern_left = 0;
   int  pattern_phase = 0;

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic level_type format_full_scale();
      level_type fs;
      fs = FS_NONE;
      case (cfg_width)
         WIDTH_8: begin
            if (cfg_kind == KIND_UNSIGNED) fs = FS_U8;
            else if (cfg_kind == KIND_SIGNED) fs = FS_S8;
         end
         WIDTH_16: begin
            if (cfg_kind == KIND_UNSIGNED) fs = FS_U16;
            else if (cfg_kind == KIND_SIGNED) fs = FS_S16;
         end
         WIDTH_32: begin
            if (cfg_kind == KIND_UNSIGNED) fs = FS_U32;
            else if (cfg_kind == KIND_SIGNED || cfg_kind == KIND_FLOAT) fs = FS_S32;
         end
         default: fs = FS_NONE;
      endcase
      return fs;
   endfunction

   // floor(|x| * (2^31 - 1)), saturated; NaN and infinity give full scale
   function automatic level_type float_level(logic [31:0] bits);
      logic [7:0]  expo;
      logic [23:0] mant;
      logic [63:0] prod;
      int          shift;
      expo = bits[30:23];
      mant = {1'b0, bits[22:0]};
      if (expo == 8'hff) return FS_S32;
      if (expo == 8'h00) expo = 8'h01;
      else mant[23] = 1'b1;
      if (mant == '0) return '0;
      prod = 64'(mant) * 64'h7fff_ffff;
      shift = 150 - int'(expo);
      if (shift <= 0) return FS_S32;
      if (shift >= 64) return '0;
      prod = prod >> shift;
      return (prod > 64'h7fff_ffff) ? FS_S32 : prod[31:0];
   endfunction

   function automatic level_type sample_level(sample_type word);
      logic [7:0]  byte0;
      logic [15:0] half;
      logic [31:0] full;
      byte0 = word[7:0];
      half = cfg_big_endian ? {word[7:0], word[15:8]} : word[15:0];
      full = cfg_big_endian ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
      case (cfg_width)
         WIDTH_8: begin
            if (cfg_kind == KIND_SIGNED && byte0[7]) return 32'(8'(8'd0 - byte0));
            return 32'(byte0);
         end
         WIDTH_16: begin
            if (cfg_kind == KIND_SIGNED && half[15]) return 32'(16'(16'd0 - half));
            return 32'(half);
         end
         default: begin
            if (cfg_kind == KIND_FLOAT) return float_level(full);
            if (cfg_kind == KIND_SIGNED && full[31]) return 32'd0 - full;
            return full;
         end
      endcase
   endfunction

   function automatic void absorb_sample(sample_type word, logic last);
      level_type       fs;
      level_type       mag;
      peak_result_type res;
      fs = format_full_scale();
      if (fs != FS_NONE) begin
         mag = sample_level(word);
         if (mag > running_peak) running_peak = mag;
      end
      if (last) begin
         if (fs != FS_NONE) held_peak = (running_peak < fs) ? running_peak : fs;
         running_peak = '0;
         res.peak_level = held_peak;
         res.full_scale = fs;
         expected_peaks.push_back(res);
      end
   endfunction

   // sample input driver: bursts of random length with random gaps
   always @(negedge clock) begin
      sample_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            item = pending_samples.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.sample_word <= item.word;
            req_ch.last_of_buffer <= item.last;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: one long hold while samples are still queued, else a pattern
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && peaks_checked >= 60 && pending_samples.size() > 50) begin
         hold_done = 1'b1;
         hold_left = LongHoldCycles;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         pattern_phase++;
         case (pattern_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= (pattern_phase % 4) != 0;
            2: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // monitor: predict on each accepted sample, check each accepted result
   always @(posedge clock) begin
      peak_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            absorb_sample(req_ch.sample_word, req_ch.last_of_buffer);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_peaks.size() == 0) begin
               report($sformatf("result with nothing expected: peak %h full scale %h",
                                rsp_ch.peak_level, rsp_ch.full_scale));
            end else begin
               want = expected_peaks.pop_front();
               if (rsp_ch.peak_level !== want.peak_level)
                  report($sformatf("peak_level got %h want %h",
                                   rsp_ch.peak_level, want.peak_level));
               if (rsp_ch.full_scale !== want.full_scale)
                  report($sformatf("full_scale got %h want %h",
                                   rsp_ch.full_scale, want.full_scale));
            end
            peaks_checked++;
         end
      end
   end

   // watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_sample(sample_type word, logic last);
      sample_item_type item;
      item.word = word;
      item.last = last;
      pending_samples.push_back(item);
      queued_samples++;
   endtask

   // hold until the pipeline is empty, then let trailing samples settle
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_ch.valid || expected_peaks.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_SAMPLE_WIDTH: cfg_width = value[1:0];
         REG_SAMPLE_KIND: cfg_kind = value[1:0];
         REG_BIG_ENDIAN: cfg_big_endian = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // upper data bits are don't-care; fill them with noise
   task automatic set_format(logic [1:0] width, logic [1:0] kind, logic big_endian);
      wait_idle();
      csr_write(REG_SAMPLE_WIDTH, {30'($urandom()), width});
      csr_write(REG_SAMPLE_KIND, {30'($urandom()), kind});
      csr_write(REG_BIG_ENDIAN, {31'($urandom()), big_endian});
   endtask

   function automatic sample_type random_word(logic [1:0] width, logic [1:0] kind,
                                              logic big_endian);
      sample_type  raw;
      logic [31:0] v;
      logic [31:0] mask;
      logic [7:0]  expo;
      raw = $urandom();
      mask = (width == WIDTH_8) ? 32'hff : (width == WIDTH_16) ? 32'hffff : 32'hffff_ffff;
      if (width == WIDTH_32 && kind == KIND_FLOAT) begin
         case ($urandom_range(0, 7))
            0: expo = 8'h00;
            1: expo = 8'hff;
            2: expo = 8'($urandom_range(125, 128));
            3: expo = 8'($urandom_range(155, 160));
            4: expo = 8'($urandom());
            default: expo = 8'($urandom_range(100, 127));
         endcase
         v = {1'($urandom()), expo, 23'($urandom())};
         if ($urandom_range(0, 9) == 0) v[22:0] = '0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: return raw;
            4: v = '0;
            5: v = mask;
            6: v = (mask >> 1) + 32'd1;
            7: v = mask >> 1;
            default: v = $urandom_range(0, 15);
         endcase
      end
      case (width)
         WIDTH_8: raw[7:0] = v[7:0];
         WIDTH_16: raw[15:0] = big_endian ? {v[7:0], v[15:8]} : v[15:0];
         default: raw = big_endian ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
      endcase
      return raw;
   endfunction

   initial begin
      logic [1:0] width;
      logic [1:0] kind;
      logic       big_endian;
      int         count;
      int         split;
      int         buf_left;

      req_ch.valid = 1'b0;
      req_ch.sample_word = '0;
      req_ch.last_of_buffer = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_SAMPLE_WIDTH;
      csr_ch.data = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset format: 16-bit signed little-endian, most negative value clamps
      push_sample(32'h1234_8000, 1'b0);
      push_sample(32'h0000_7fff, 1'b1);
      push_sample(32'hffff_ffff, 1'b1);

      set_format(WIDTH_8, KIND_UNSIGNED, 1'b0);
      push_sample(32'hffff_ff00, 1'b0);
      push_sample(32'h0000_00ff, 1'b1);

      set_format(WIDTH_8, KIND_SIGNED, 1'b0);
      push_sample(32'h0000_0080, 1'b1);
      push_sample(32'hffff_ff7f, 1'b1);

      set_format(WIDTH_16, KIND_UNSIGNED, 1'b1);
      push_sample(32'h0000_ffff, 1'b1);
      push_sample(32'h0000_0100, 1'b1);

      // buffer left open across a format change: the clamp uses the new format
      set_format(WIDTH_32, KIND_UNSIGNED, 1'b1);
      push_sample(32'h0403_0201, 1'b1);
      push_sample(32'hffff_ffff, 1'b0);
      set_format(WIDTH_8, KIND_UNSIGNED, 1'b0);
      push_sample(32'h0000_0000, 1'b1);

      set_format(WIDTH_32, KIND_SIGNED, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      push_sample(32'h0000_0000, 1'b1);

      // float: NaN, negative infinity, half, negative denormal, one
      set_format(WIDTH_32, KIND_FLOAT, 1'b0);
      push_sample(32'h7fc0_0000, 1'b1);
      push_sample(32'hff80_0000, 1'b1);
      push_sample(32'h3f00_0000, 1'b1);
      push_sample(32'h8000_0001, 1'b1);
      push_sample(32'h3f80_0000, 1'b1);

      set_format(WIDTH_32, KIND_FLOAT, 1'b1);
      push_sample(32'h0000_803f, 1'b1);

      // unsupported formats repeat the stored peak with zero full scale
      set_format(WIDTH_16, KIND_FLOAT, 1'b0);
      push_sample(32'h3f80_0000, 1'b1);
      set_format(WIDTH_RESERVED, KIND_UNSIGNED, 1'b0);
      push_sample(32'h1234_5678, 1'b1);
      set_format(WIDTH_32, KIND_RESERVED, 1'b1);
      push_sample(32'hffff_ffff, 1'b1);

      buf_left = 0;
      while (queued_samples < ItemTarget) begin
         if ($urandom_range(0, 5) == 0) begin
            width = 2'($urandom_range(0, 3));
            kind = 2'($urandom_range(0, 3));
         end else begin
            case ($urandom_range(0, 6))
               0: begin width = WIDTH_8; kind = KIND_UNSIGNED; end
               1: begin width = WIDTH_8; kind = KIND_SIGNED; end
               2: begin width = WIDTH_16; kind = KIND_UNSIGNED; end
               3: begin width = WIDTH_16; kind = KIND_SIGNED; end
               4: begin width = WIDTH_32; kind = KIND_UNSIGNED; end
               5: begin width = WIDTH_32; kind = KIND_SIGNED; end
               default: begin width = WIDTH_32; kind = KIND_FLOAT; end
            endcase
         end
         big_endian = 1'($urandom_range(0, 1));
         set_format(width, kind, big_endian);
         count = $urandom_range(40, 140);
         split = ($urandom_range(0, 4) == 0) ? $urandom_range(1, count - 1) : 0;
         for (int i = 0; i < count; i++) begin
            // pause the sender until every pending peak has been returned
            if (split != 0 && i == split) wait_idle();
            if (buf_left == 0)
               buf_left = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                      : $urandom_range(1, 8);
            buf_left--;
            push_sample(random_word(width, kind, big_endian), buf_left == 0);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
